### design/lc3s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3s_pkg
// Shared types, instruction codes and helper functions of the LC-3 subset core.
// ----------------------------------------------------------------------------
package lc3s_pkg;

    // item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // opcodes of the supported subset
    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_TRAP = 4'd15;

    // condition code bit positions
    localparam int CC_N_BIT = 2;
    localparam int CC_Z_BIT = 1;
    localparam int CC_P_BIT = 0;

    localparam int          REG_COUNT      = 8;
    localparam int          OUTQ_DEPTH     = 2;
    localparam logic [7:0]  HALT_VECTOR_RST = 8'd37;

    typedef struct packed {
        logic        cmd;
        logic [4:0]  load_addr;
        logic [15:0] load_data;
    } in_t;

    typedef struct packed {
        logic [15:0] pc_now;
        logic [15:0] instr;
        logic        flag_neg;
        logic        flag_zero;
        logic        flag_pos;
        logic        reg_written;
        logic [2:0]  dest_index;
        logic [15:0] dest_value;
        logic        mem_written;
        logic        halted;
    } out_t;

    // what one executed instruction changes
    typedef struct packed {
        logic        reg_we;
        logic [2:0]  dest;
        logic [15:0] dval;
        logic        mem_we;
        logic [15:0] mem_addr;
        logic [15:0] pc_new;
        logic [2:0]  cc_new;
        logic        halt_set;
    } exec_res_t;

    function automatic logic [15:0] sext9(input logic [15:0] ir);
        return {{7{ir[8]}}, ir[8:0]};
    endfunction

    function automatic logic [15:0] sext5(input logic [15:0] ir);
        return {{11{ir[4]}}, ir[4:0]};
    endfunction

    function automatic logic [2:0] codes_of(input logic [15:0] v);
        logic [2:0] cc;
        cc = '0;
        if (v == 16'd0) begin
            cc[CC_Z_BIT] = 1'b1;
        end else if (v[15]) begin
            cc[CC_N_BIT] = 1'b1;
        end else begin
            cc[CC_P_BIT] = 1'b1;
        end
        return cc;
    endfunction

endpackage
`default_nettype wire

### design/lc3s_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3s_ram
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written returns the old word.
// ----------------------------------------------------------------------------
module lc3s_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### design/lc3s_wrap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3s_wrap
// Reduces a 16-bit address to a memory word index modulo DEPTH.
// Power-of-two depths take the low bits; others use an exact reciprocal.
// ----------------------------------------------------------------------------
module lc3s_wrap #(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic [15:0]   addr,
    output logic      [AW-1:0] idx
);

    generate
        if ((DEPTH & (DEPTH - 1)) == 0) begin : g_pow2
            assign idx = addr[AW-1:0];
        end else begin : g_recip
            // quotient is exact for 16-bit dividends with a 33-bit scale
            localparam logic [33:0] RECIP =
                34'(((64'd1 << 33) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));
            logic [49:0] prod;
            logic [15:0] quot;
            logic [15:0] back;
            logic [15:0] rem;

            assign prod = 50'(addr) * 50'(RECIP);
            assign quot = prod[48:33];
            assign back = 16'(quot * 16'(DEPTH));
            assign rem  = addr - back;
            assign idx  = rem[AW-1:0];
        end
    endgenerate

endmodule
`default_nettype wire

### design/lc3s_exec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3s_exec
// Execute logic: decodes one instruction word and works out the register
// write, memory store, next PC, condition codes and halt request.
// ----------------------------------------------------------------------------
module lc3s_exec (
    input  wire logic [15:0]         ir,
    input  wire logic [15:0]         pc_inc,
    input  wire logic [15:0]         rs1,
    input  wire logic [15:0]         rs2,
    input  wire logic [15:0]         ld_data,
    input  wire logic [2:0]          cc,
    input  wire logic [7:0]          halt_vec,
    output lc3s_pkg::exec_res_t      res
);

    import lc3s_pkg::*;

    logic [15:0] target;
    logic [15:0] opnd_b;
    logic        br_taken;

    assign target   = pc_inc + sext9(ir);
    assign opnd_b   = ir[5] ? sext5(ir) : rs2;
    assign br_taken = (ir[11] & cc[CC_N_BIT]) | (ir[10] & cc[CC_Z_BIT]) |
                      (ir[9] & cc[CC_P_BIT]);

    always_comb begin
        res          = '0;
        res.mem_addr = target;
        res.pc_new   = pc_inc;
        unique case (ir[15:12])
            OP_ADD: begin
                res.reg_we = 1'b1;
                res.dest   = ir[11:9];
                res.dval   = rs1 + opnd_b;
            end
            OP_AND: begin
                res.reg_we = 1'b1;
                res.dest   = ir[11:9];
                res.dval   = rs1 & opnd_b;
            end
            OP_NOT: begin
                res.reg_we = 1'b1;
                res.dest   = ir[11:9];
                res.dval   = ~rs1;
            end
            OP_LD: begin
                res.reg_we = 1'b1;
                res.dest   = ir[11:9];
                res.dval   = ld_data;
            end
            OP_ST: begin
                res.mem_we = 1'b1;
            end
            OP_BR: begin
                if (br_taken) begin
                    res.pc_new = target;
                end
            end
            OP_JMP: begin
                res.pc_new = rs1;
            end
            OP_TRAP: begin
                res.halt_set = (ir[7:0] == halt_vec);
            end
            default: begin
                // unsupported opcodes only advance the PC
            end
        endcase
        res.cc_new = res.reg_we ? codes_of(res.dval) : cc;
    end

endmodule
`default_nettype wire

### design/lc3s_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3s_outq
// Two-entry result queue that decouples execution from the result consumer.
// ----------------------------------------------------------------------------
module lc3s_outq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire lc3s_pkg::out_t  push_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output lc3s_pkg::out_t       m_data
);

    import lc3s_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);

    out_t            slot_reg [OUTQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            pop;

    assign m_valid = (cnt_reg != '0);
    assign m_data  = slot_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PW + 1)'(push) - (PW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### design/lc3_subset_cpu_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3_subset_cpu_step
// LC-3 subset core: word memory and register file in synchronous RAMs.
// Results pass the fetch registers (b_*), the execute registers (c_*) and the queue.
// Steps: fetch read, operand and load reads, then execute and write back overlapping
// the next request's fetch. No request is taken while one is in fetch or the queue
// may be full. Reset: a clearing pass zeroes memory and loads register i with i;
// no request is taken until it ends. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module lc3_subset_cpu_step #(
    parameter int MEM_WORDS = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire lc3s_pkg::in_t   s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output lc3s_pkg::out_t       m_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [7:0]      cfg_data
);

    import lc3s_pkg::*;

    localparam int AW  = $clog2(MEM_WORDS);
    localparam int RAW = $clog2(REG_COUNT);

    // configuration and architectural state
    logic [7:0]  halt_vec_reg;
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  cc_reg, cc_next;
    logic        halt_reg, halt_next;

    // clearing pass
    logic [AW:0] clr_cnt_reg, clr_cnt_next;
    logic        init_done;

    // pipeline registers
    logic        b_valid_reg, c_valid_reg;
    logic        b_cmd_reg, c_cmd_reg;
    logic [4:0]  b_addr_reg;
    logic [15:0] b_data_reg;
    logic [15:0] b_pc_reg;
    logic [15:0] c_ir_reg;
    logic [15:0] c_pc_inc_reg;
    logic        fwd_hit_reg, fwd_hit_next;
    logic [15:0] fwd_data_reg;

    logic [1:0]  occ_reg, occ_next;
    logic        in_acc, out_acc;

    // memory ports
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [15:0]     mem_wdata, mem_rdata;
    logic            rf_we;
    logic [RAW-1:0]  rf_waddr, rf_raddr_a, rf_raddr_b;
    logic [15:0]     rf_wdata, rf_rdata_a, rf_rdata_b;

    logic [15:0]     b_ir, b_pc_inc, b_ld_addr;
    logic [AW-1:0]   ld_idx, load_idx, fetch_idx, st_idx;
    exec_res_t       res;
    logic            c_live;
    out_t            result;

    assign cfg_ready = 1'b1;
    assign init_done = (clr_cnt_reg == (AW + 1)'(MEM_WORDS));
    assign s_ready   = init_done && !b_valid_reg && (occ_reg < 2'(OUTQ_DEPTH));
    assign in_acc    = s_valid && s_ready;
    assign out_acc   = m_valid && m_ready;

    // ---------------- fetch / operand stage ----------------
    assign b_ir      = fwd_hit_reg ? fwd_data_reg : mem_rdata;
    assign b_pc_inc  = b_pc_reg + 16'd1;
    assign b_ld_addr = b_pc_inc + sext9(b_ir);
    assign rf_raddr_a = b_ir[8:6];
    assign rf_raddr_b = (b_ir[15:12] == OP_ST) ? b_ir[11:9] : b_ir[2:0];

    lc3s_wrap #(.DEPTH(MEM_WORDS)) u_wrap_ld (.addr(b_ld_addr), .idx(ld_idx));
    lc3s_wrap #(.DEPTH(MEM_WORDS)) u_wrap_load (.addr(16'(b_addr_reg)), .idx(load_idx));

    // ---------------- execute stage ----------------
    lc3s_exec u_exec (
        .ir       (c_ir_reg),
        .pc_inc   (c_pc_inc_reg),
        .rs1      (rf_rdata_a),
        .rs2      (rf_rdata_b),
        .ld_data  (mem_rdata),
        .cc       (cc_reg),
        .halt_vec (halt_vec_reg),
        .res      (res)
    );

    assign c_live = c_valid_reg && (c_cmd_reg == CMD_STEP) && !halt_reg;

    always_comb begin
        pc_next   = c_live ? res.pc_new : pc_reg;
        cc_next   = c_live ? res.cc_new : cc_reg;
        halt_next = halt_reg || (c_live && res.halt_set);
    end

    lc3s_wrap #(.DEPTH(MEM_WORDS)) u_wrap_fetch (.addr(pc_next), .idx(fetch_idx));
    lc3s_wrap #(.DEPTH(MEM_WORDS)) u_wrap_st (.addr(res.mem_addr), .idx(st_idx));

    // a store in execute and the next fetch share a cycle: forward the stored word
    assign fwd_hit_next = c_live && res.mem_we && (st_idx == fetch_idx);

    always_comb begin
        result             = '0;
        result.pc_now      = pc_next;
        result.instr       = c_live ? c_ir_reg : 16'd0;
        result.flag_neg    = cc_next[CC_N_BIT];
        result.flag_zero   = cc_next[CC_Z_BIT];
        result.flag_pos    = cc_next[CC_P_BIT];
        result.reg_written = c_live && res.reg_we;
        result.dest_index  = result.reg_written ? res.dest : 3'd0;
        result.dest_value  = result.reg_written ? res.dval : 16'd0;
        result.mem_written = c_live && res.mem_we;
        result.halted      = halt_next;
    end

    // ---------------- memory port selection ----------------
    assign mem_raddr = b_valid_reg ? ld_idx : fetch_idx;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg[AW-1:0];
        mem_wdata = 16'd0;
        priority if (!init_done) begin
            mem_we = 1'b1;
        end else if (b_valid_reg && (b_cmd_reg == CMD_LOAD)) begin
            mem_we    = 1'b1;
            mem_waddr = load_idx;
            mem_wdata = b_data_reg;
        end else if (c_live && res.mem_we) begin
            mem_we    = 1'b1;
            mem_waddr = st_idx;
            mem_wdata = rf_rdata_b;
        end
    end

    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = clr_cnt_reg[RAW-1:0];
        rf_wdata = 16'(clr_cnt_reg[RAW-1:0]);
        priority if (!init_done) begin
            rf_we = (clr_cnt_reg < (AW + 1)'(REG_COUNT));
        end else if (c_live && res.reg_we) begin
            rf_we    = 1'b1;
            rf_waddr = res.dest;
            rf_wdata = res.dval;
        end
    end

    lc3s_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // register file: two copies written together give two read ports
    lc3s_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf_a (
        .clk   (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr_a),
        .rdata (rf_rdata_a)
    );

    lc3s_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf_b (
        .clk   (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr_b),
        .rdata (rf_rdata_b)
    );

    lc3s_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (c_valid_reg),
        .push_data (result),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // ---------------- registers ----------------
    always_comb begin
        clr_cnt_next = init_done ? clr_cnt_reg : clr_cnt_reg + 1'b1;
        occ_next     = occ_reg + 2'(in_acc) - 2'(out_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_vec_reg <= HALT_VECTOR_RST;
            pc_reg       <= '0;
            cc_reg       <= '0;
            halt_reg     <= 1'b0;
            clr_cnt_reg  <= '0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            occ_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                halt_vec_reg <= cfg_data;
            end
            pc_reg      <= pc_next;
            cc_reg      <= cc_next;
            halt_reg    <= halt_next;
            clr_cnt_reg <= clr_cnt_next;
            b_valid_reg <= in_acc;
            c_valid_reg <= b_valid_reg;
            occ_reg     <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            b_cmd_reg  <= s_data.cmd;
            b_addr_reg <= s_data.load_addr;
            b_data_reg <= s_data.load_data;
            b_pc_reg   <= pc_next;
        end
        c_cmd_reg    <= b_cmd_reg;
        c_ir_reg     <= b_ir;
        c_pc_inc_reg <= b_pc_inc;
        fwd_hit_reg  <= fwd_hit_next;
        fwd_data_reg <= rf_rdata_b;
    end

endmodule
`default_nettype wire

### design/lc3s_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3s_checker
// Port-level checks of the LC-3 subset core, bound to the top level.
// ----------------------------------------------------------------------------
module lc3s_checker (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic            s_ready,
    input  wire logic            m_valid,
    input  wire logic            m_ready,
    input  wire lc3s_pkg::out_t  m_data
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // s_ready drops after every accepted request
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken on consecutive cycles");

    // once halted, the next result is still halted and the PC stays
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.halted) ##1 m_valid |->
            m_data.halted && (m_data.pc_now == $past(m_data.pc_now)))
        else $error("halted core changed state");

    // unused destination fields read zero, and no step writes both places
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.reg_written && m_data.mem_written) &&
            (m_data.reg_written ||
             (m_data.dest_index == 3'd0 && m_data.dest_value == 16'd0)))
        else $error("inconsistent write report");

endmodule

bind lc3_subset_cpu_step lc3s_checker u_lc3s_checker (.*);
`default_nettype wire

### tb/lc3_subset_cpu_step_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3_subset_cpu_step_test
// Self-checking bench for the LC-3 subset core. Each accepted request runs
// through a cycle-free model of the core (registers, memory, PC, condition
// codes, halt latch), and the predicted report is queued. A monitor compares
// every accepted report field by field with the oldest prediction. Stimulus
// is a short hand-built program, trap vector checks, random load-and-run
// program chunks under several halt vectors, a long result stall, and the
// halt sequence last, since only reset clears the halt latch.
// ----------------------------------------------------------------------------
module lc3_subset_cpu_step_test;
    import lc3s_pkg::*;

    localparam int MEM_WORDS = 32;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam logic [3:0] OP_JSR = 4'd4;  // not part of the subset

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    logic [7:0] cfg_data = '0;

    // model of the core
    logic [15:0] gpr [REG_COUNT];
    logic [15:0] mem_img [MEM_WORDS];
    logic [15:0] pc_q;
    logic [2:0]  cc_q;
    logic        halted_q;
    logic [7:0]  halt_vec_q;

    out_t pending_reports[$];
    int   mismatches = 0;
    int   items_sent = 0;
    int   quiet_cycles = 0;
    bit   idle_off = 1'b0;
    int   hold_ask = 0;
    int   hold_seen = 0;
    int   stall_left = 0;

    lc3_subset_cpu_step #(
        .MEM_WORDS(MEM_WORDS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic logic [4:0] word_index(logic [15:0] a);
        return 5'(a % MEM_WORDS);
    endfunction

    function automatic logic [15:0] encode(logic [3:0] op, logic [2:0] f, logic [8:0] low);
        return {op, f, low};
    endfunction

    // Apply one request to the model and return the report it should produce.
    function automatic out_t next_report(in_t req);
        out_t r;
        logic [15:0] ir;
        logic [15:0] ea;
        logic [15:0] opnd;
        r = '0;
        if (req.cmd == CMD_LOAD) begin
            mem_img[req.load_addr] = req.load_data;
        end else if (!halted_q) begin
            ir = mem_img[word_index(pc_q)];
            pc_q = pc_q + 16'd1;
            ea = pc_q + {{7{ir[8]}}, ir[8:0]};
            r.instr = ir;
            case (ir[15:12])
                OP_ADD, OP_AND: begin
                    opnd = ir[5] ? {{11{ir[4]}}, ir[4:0]} : gpr[ir[2:0]];
                    r.reg_written = 1'b1;
                    r.dest_index = ir[11:9];
                    r.dest_value = (ir[15:12] == OP_ADD) ? gpr[ir[8:6]] + opnd
                                                         : gpr[ir[8:6]] & opnd;
                end
                OP_NOT: begin
                    r.reg_written = 1'b1;
                    r.dest_index = ir[11:9];
                    r.dest_value = ~gpr[ir[8:6]];
                end
                OP_LD: begin
                    r.reg_written = 1'b1;
                    r.dest_index = ir[11:9];
                    r.dest_value = mem_img[word_index(ea)];
                end
                OP_ST: begin
                    mem_img[word_index(ea)] = gpr[ir[11:9]];
                    r.mem_written = 1'b1;
                end
                OP_BR: begin
                    // instruction bits 11..9 line up with N, Z, P
                    if ((ir[11:9] & cc_q) != 3'b000) begin
                        pc_q = ea;
                    end
                end
                OP_JMP: begin
                    pc_q = gpr[ir[8:6]];
                end
                OP_TRAP: begin
                    if (ir[7:0] == halt_vec_q) begin
                        halted_q = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (r.reg_written) begin
                gpr[r.dest_index] = r.dest_value;
                cc_q = '0;
                if (r.dest_value == 16'd0) begin
                    cc_q[CC_Z_BIT] = 1'b1;
                end else if (r.dest_value[15]) begin
                    cc_q[CC_N_BIT] = 1'b1;
                end else begin
                    cc_q[CC_P_BIT] = 1'b1;
                end
            end
        end
        r.pc_now = pc_q;
        r.flag_neg = cc_q[CC_N_BIT];
        r.flag_zero = cc_q[CC_Z_BIT];
        r.flag_pos = cc_q[CC_P_BIT];
        r.halted = halted_q;
        return r;
    endfunction

    function automatic logic [15:0] rand_instr();
        logic [15:0] w;
        w = 16'($urandom());
        case ($urandom_range(10))
            0: w[15:12] = OP_BR;
            1, 2: w[15:12] = OP_ADD;
            3, 4: w[15:12] = OP_AND;
            5: w[15:12] = OP_NOT;
            6: w[15:12] = OP_LD;
            7: w[15:12] = OP_ST;
            8: w[15:12] = OP_JMP;
            9: w[15:12] = OP_TRAP;
            default: begin
                // keep the raw word: any opcode, supported or not
            end
        endcase
        return w;
    endfunction

    // Call right after a rising edge; leaves valid high after acceptance.
    task automatic issue_request(in_t req);
        if (!idle_off && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        pending_reports.push_back(next_report(req));
        items_sent++;
    endtask

    task automatic load_word(logic [4:0] addr, logic [15:0] data);
        in_t req;
        req.cmd = CMD_LOAD;
        req.load_addr = addr;
        req.load_data = data;
        issue_request(req);
    endtask

    task automatic step_core(bit may_halt);
        logic [15:0] w;
        in_t req;
        w = mem_img[word_index(pc_q)];
        // defuse a halting trap until the halt test
        if (!may_halt && !halted_q && w[15:12] == OP_TRAP && w[7:0] == halt_vec_q) begin
            load_word(word_index(pc_q), w ^ 16'h0001);
        end
        req.cmd = CMD_STEP;
        req.load_addr = 5'($urandom());
        req.load_data = 16'($urandom());
        issue_request(req);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
    endtask

    task automatic set_halt_vector(logic [7:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        halt_vec_q = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly load a chunk at the PC and run through it; the rest is noise.
    task automatic run_random_phase(int n_items);
        int stop_at;
        int k;
        logic [4:0] base;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(9))
                0: load_word(5'($urandom()), 16'($urandom()));
                1: step_core(1'b0);
                default: begin
                    k = $urandom_range(1, 8);
                    base = word_index(pc_q);
                    for (int i = 0; i < k; i++) begin
                        load_word(base + 5'(i), rand_instr());
                    end
                    repeat ($urandom_range(k, k + 3)) step_core(1'b0);
                end
            endcase
        end
    endtask

    task automatic test_directed_program();
        logic [15:0] prog [13];
        prog = '{
            encode(OP_BR,   3'b111, 9'h000),              // no codes set yet: not taken
            encode(OP_ADD,  3'd1,   {3'd7, 1'b1, 5'b10000}),
            encode(OP_ADD,  3'd2,   {3'd1, 1'b1, 5'b01111}),
            encode(OP_AND,  3'd3,   {3'd2, 1'b1, 5'b00000}),
            encode(OP_ADD,  3'd4,   {3'd1, 1'b0, 5'b11010}), // bits 4..3 ignored
            encode(OP_NOT,  3'd6,   {3'd3, 6'b111111}),
            encode(OP_ST,   3'd2,   9'h009),
            encode(OP_LD,   3'd0,   9'h100),              // wraps around memory
            encode(OP_BR,   3'b100, 9'h0FF),
            encode(OP_BR,   3'b001, 9'h100),              // PC goes below zero
            encode(OP_TRAP, 3'b000, 9'h019),              // 25 is not the halt vector
            encode(OP_JSR,  3'b111, 9'h1FF),
            encode(OP_JMP,  3'b000, {3'd6, 6'd0})         // jump to 0xFFFF
        };
        foreach (prog[i]) begin
            load_word(5'(i), prog[i]);
        end
        load_word(5'(MEM_WORDS - 1), encode(OP_ADD, 3'd7, {3'd7, 1'b1, 5'd1}));
        repeat (14) step_core(1'b0);
    endtask

    task automatic test_trap_vectors();
        set_halt_vector(8'h00);
        load_word(word_index(pc_q), encode(OP_TRAP, 3'b000, 9'h0FF));
        step_core(1'b0);
        load_word(word_index(pc_q), encode(OP_TRAP, 3'b000, {1'b0, HALT_VECTOR_RST}));
        step_core(1'b0);
        set_halt_vector(8'hFF);
        load_word(word_index(pc_q), encode(OP_TRAP, 3'b000, 9'h000));
        step_core(1'b0);
    endtask

    task automatic test_random_programs();
        logic [7:0] vectors [4];
        vectors = '{8'h00, 8'($urandom()), 8'hFF, 8'($urandom())};
        foreach (vectors[i]) begin
            set_halt_vector(vectors[i]);
            idle_off = (i == 1);
            run_random_phase(140);
        end
        idle_off = 1'b0;
    endtask

    task automatic test_backpressure();
        drain_results();
        idle_off = 1'b1;
        hold_ask++;
        run_random_phase(40);
        idle_off = 1'b0;
        drain_results();
    endtask

    task automatic test_halt();
        set_halt_vector(8'h19);
        load_word(word_index(pc_q), encode(OP_TRAP, 3'b000, 9'h019));
        step_core(1'b1);
        repeat (3) step_core(1'b1);
        load_word(5'($urandom()), 16'($urandom()));
        step_core(1'b1);
        set_halt_vector(8'h00);
        step_core(1'b1);
    endtask

    initial begin
        for (int i = 0; i < REG_COUNT; i++) begin
            gpr[i] = 16'(i);
        end
        foreach (mem_img[i]) begin
            mem_img[i] = '0;
        end
        pc_q = '0;
        cc_q = '0;
        halted_q = 1'b0;
        halt_vec_q = HALT_VECTOR_RST;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_program();
        test_trap_vectors();
        test_random_programs();
        test_backpressure();
        test_halt();
        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // result side: random stalls, plus one long hold on request
    always @(posedge aclk) begin
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= idle_off || ($urandom_range(99) >= 17);
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("report with no request outstanding: %p", m_data);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("pc_now", want.pc_now, m_data.pc_now);
                check_field("instr", want.instr, m_data.instr);
                check_field("flag_neg", want.flag_neg, m_data.flag_neg);
                check_field("flag_zero", want.flag_zero, m_data.flag_zero);
                check_field("flag_pos", want.flag_pos, m_data.flag_pos);
                check_field("reg_written", want.reg_written, m_data.reg_written);
                check_field("dest_index", want.dest_index, m_data.dest_index);
                check_field("dest_value", want.dest_value, m_data.dest_value);
                check_field("mem_written", want.mem_written, m_data.mem_written);
                check_field("halted", want.halted, m_data.halted);
            end
        end
    end

    // drop the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
